// File: rtl/rvlsu_pkg.sv
// Shared definitions for the RV32I load/store unit: instruction kinds,
// funct3 width codes, default memory size and the load control bundle.
// No dependencies.
package rvlsu_pkg;

    // Default data memory size in bytes (power of two, 16 .. 16M)
    localparam int unsigned MEM_BYTES_DEF = 65536;

    // Instruction kinds
    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_STORE = 2'd2;

    // funct3 width codes
    localparam logic [2:0] F3_B  = 3'b000;
    localparam logic [2:0] F3_H  = 3'b001;
    localparam logic [2:0] F3_W  = 3'b010;
    localparam logic [2:0] F3_BU = 3'b100;
    localparam logic [2:0] F3_HU = 3'b101;

    // Control that travels with an item from address generation to load extension
    typedef struct packed {
        logic       valid;
        logic       is_load;
        logic [2:0] width_code;
        logic [4:0] dest_reg;
        logic [1:0] lane;
    } t_ld_ctl;

endpackage

// File: rtl/rvlsu_bank.sv
// One byte lane of the data memory: one write port, one registered read port.
// Depends on nothing.
module rvlsu_bank #(
    parameter int unsigned ROWS  = 16384,
    parameter int unsigned ROW_W = 14
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [ROW_W-1:0] i_row,
    input  logic [7:0]       i_wdata,
    output logic [7:0]       o_rdata
);

    logic [7:0] r_mem [ROWS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_row] <= i_wdata;
        end
        o_rdata <= r_mem[i_row];
    end

endmodule

// File: rtl/rvlsu_agen.sv
// Input register and address generation: effective address, per-lane row,
// write enables and store bytes. Depends on rvlsu_pkg.
module rvlsu_agen #(
    parameter int unsigned ADDR_W = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_take,
    input  logic [1:0]                  i_kind,
    input  logic [2:0]                  i_width_code,
    input  logic [31:0]                 i_base_value,
    input  logic signed [11:0]          i_offset,
    input  logic [31:0]                 i_store_data,
    input  logic [4:0]                  i_dest_reg,
    output logic [3:0][ADDR_W-3:0]      o_row,
    output logic [3:0]                  o_we,
    output logic [3:0][7:0]             o_wdata,
    output rvlsu_pkg::t_ld_ctl          o_ctl
);

    localparam int unsigned ROW_W = ADDR_W - 2;

    logic        r_valid;
    logic [1:0]  r_kind;
    logic [2:0]  r_wcode;
    logic [31:0] r_base;
    logic [11:0] r_off;
    logic [31:0] r_sdata;
    logic [4:0]  r_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_kind  <= i_kind;
            r_wcode <= i_width_code;
            r_base  <= i_base_value;
            r_off   <= i_offset;
            r_sdata <= i_store_data;
            r_rd    <= i_dest_reg;
        end
    end

    logic [31:0]       addr;
    logic [1:0]        lane;
    logic [ROW_W-1:0]  row;
    logic [2:0]        nbytes;
    logic [3:0][1:0]   idx;
    logic              is_store;

    always_comb begin
        addr     = r_base + {{20{r_off[11]}}, r_off};
        lane     = addr[1:0];
        row      = addr[ADDR_W-1:2];
        is_store = r_valid && (r_kind == rvlsu_pkg::KIND_STORE);
        case (r_wcode)
            rvlsu_pkg::F3_B: nbytes = 3'd1;
            rvlsu_pkg::F3_H: nbytes = 3'd2;
            rvlsu_pkg::F3_W: nbytes = 3'd4;
            default:         nbytes = 3'd0;
        endcase
        for (int b = 0; b < 4; b++) begin
            // byte b of the lane set holds byte idx of the access
            idx[b]     = 2'(b) - lane;
            // lanes below the start lane wrap into the next row
            o_row[b]   = row + ROW_W'(2'(b) < lane);
            o_we[b]    = is_store && ({1'b0, idx[b]} < nbytes);
            o_wdata[b] = r_sdata[8*idx[b] +: 8];
        end
        o_ctl.valid      = r_valid;
        o_ctl.is_load    = r_valid && (r_kind == rvlsu_pkg::KIND_LOAD);
        o_ctl.width_code = r_wcode;
        o_ctl.dest_reg   = r_rd;
        o_ctl.lane       = lane;
    end

endmodule

// File: rtl/rvlsu_ldext.sv
// Load alignment and extension: rotates the four read lanes into place,
// sign- or zero-extends, and holds the result register. Depends on rvlsu_pkg.
module rvlsu_ldext (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rvlsu_pkg::t_ld_ctl i_ctl,
    input  logic [3:0][7:0]    i_rdata,
    output logic [31:0]        o_load_value,
    output logic [4:0]         o_dest_reg_out,
    output logic               o_writes_back,
    output logic               o_valid
);

    rvlsu_pkg::t_ld_ctl r_ctl;
    logic [31:0]        r_load_value;
    logic [4:0]         r_dest;
    logic               r_wb;
    logic               r_valid;

    logic [31:0] word;
    logic [31:0] n_load_value;
    logic [4:0]  n_dest;
    logic        n_wb;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            word[8*i +: 8] = i_rdata[2'(i) + r_ctl.lane];
        end
        n_wb         = 1'b1;
        n_load_value = 32'd0;
        case (r_ctl.width_code)
            rvlsu_pkg::F3_B:  n_load_value = {{24{word[7]}}, word[7:0]};
            rvlsu_pkg::F3_H:  n_load_value = {{16{word[15]}}, word[15:0]};
            rvlsu_pkg::F3_W:  n_load_value = word;
            rvlsu_pkg::F3_BU: n_load_value = {24'd0, word[7:0]};
            rvlsu_pkg::F3_HU: n_load_value = {16'd0, word[15:0]};
            default:          n_wb = 1'b0;
        endcase
        // drop everything that is not a supported load
        if (!(r_ctl.is_load && n_wb)) begin
            n_wb         = 1'b0;
            n_load_value = 32'd0;
        end
        n_dest = n_wb ? r_ctl.dest_reg : 5'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_ctl   <= i_ctl;
            r_valid <= r_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_load_value <= n_load_value;
        r_dest       <= n_dest;
        r_wb         <= n_wb;
    end

    assign o_load_value   = r_load_value;
    assign o_dest_reg_out = r_dest;
    assign o_writes_back  = r_wb;
    assign o_valid        = r_valid;

endmodule

// File: rtl/riscv_load_store_unit_core.sv
// RV32I memory stage top level: address generation, four byte-lane memory
// banks and load extension. Depends on rvlsu_pkg, rvlsu_agen, rvlsu_bank, rvlsu_ldext.
//
// Usage:
//   Command in: raise start with the instruction fields; the item is taken at
//   any rising edge where start is high and busy is low. busy is low whenever
//   reset is released, so one item can be taken every cycle.
//   Result out: every item gives one result, shown for exactly one cycle with
//   o_valid high. It passes the input register, the bank read registers and
//   the result register in that order. Results leave in item order.
//   Loads give the extended value and destination with o_writes_back set;
//   stores, other kinds and unlisted width codes give an all-zero result.
//   The receiver cannot stall; it must take each result as it appears.
//   Throughput is one item per cycle, set by the single-pass pipeline
//   (input register, one registered read on each byte-lane bank, result
//   register); a load sees every store taken before it.
//   Reset (synchronous, active low) clears the pipeline valid flags and
//   holds busy high. Data memory contents are not cleared and are undefined
//   until written. MEM_BYTES must be a power of two.
module riscv_load_store_unit_core #(
    parameter int unsigned MEM_BYTES = rvlsu_pkg::MEM_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_kind,
    input  logic [2:0]         i_width_code,
    input  logic [31:0]        i_base_value,
    input  logic signed [11:0] i_offset,
    input  logic [31:0]        i_store_data,
    input  logic [4:0]         i_dest_reg,
    output logic [31:0]        o_load_value,
    output logic [4:0]         o_dest_reg_out,
    output logic               o_writes_back,
    output logic               o_valid
);

    localparam int unsigned ADDR_W = $clog2(MEM_BYTES);
    localparam int unsigned ROW_W  = ADDR_W - 2;
    localparam int unsigned ROWS   = MEM_BYTES / 4;

    logic [3:0][ROW_W-1:0] row;
    logic [3:0]            we;
    logic [3:0][7:0]       wdata;
    logic [3:0][7:0]       rdata;
    rvlsu_pkg::t_ld_ctl    ctl;

    assign busy = ~i_rst_n;

    rvlsu_agen #(
        .ADDR_W (ADDR_W)
    ) u_agen (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (start & ~busy),
        .i_kind       (i_kind),
        .i_width_code (i_width_code),
        .i_base_value (i_base_value),
        .i_offset     (i_offset),
        .i_store_data (i_store_data),
        .i_dest_reg   (i_dest_reg),
        .o_row        (row),
        .o_we         (we),
        .o_wdata      (wdata),
        .o_ctl        (ctl)
    );

    for (genvar b = 0; b < 4; b++) begin : g_bank
        rvlsu_bank #(
            .ROWS  (ROWS),
            .ROW_W (ROW_W)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (we[b]),
            .i_row   (row[b]),
            .i_wdata (wdata[b]),
            .o_rdata (rdata[b])
        );
    end

    rvlsu_ldext u_ldext (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_rdata        (rdata),
        .o_load_value   (o_load_value),
        .o_dest_reg_out (o_dest_reg_out),
        .o_writes_back  (o_writes_back),
        .o_valid        (o_valid)
    );

endmodule

// File: dv/tb_top.sv
// Testbench for riscv_load_store_unit_core: directed and random loads/stores with a
// scoreboard that mirrors the data memory and checks every result in order.
// Depends on rvlsu_pkg and the RTL top level only.
`timescale 1ns / 1ps

localparam logic [1:0] KIND_RSVD = 2'd3;
localparam logic [2:0] F3_RSVD_A = 3'b011;
localparam logic [2:0] F3_RSVD_B = 3'b110;
localparam logic [2:0] F3_RSVD_C = 3'b111;

typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  wc;
    logic [31:0] base;
    logic [11:0] off;
    logic [31:0] data;
    logic [4:0]  rd;
} t_lsu_cmd;

typedef struct packed {
    logic [31:0] value;
    logic [4:0]  rd;
    logic        wb;
} t_lsu_result;

class lsu_scoreboard;
    localparam int unsigned MEM_SIZE = rvlsu_pkg::MEM_BYTES_DEF;

    bit [7:0]    mem_img [MEM_SIZE];
    bit          written [MEM_SIZE];
    t_lsu_result pending_q [$];
    int          n_items, n_loads, n_stores, n_other, n_checked, n_errors;

    function int unsigned eff_addr(logic [31:0] base, logic [11:0] off);
        logic [31:0] a;
        a = base + {{20{off[11]}}, off};
        return a % MEM_SIZE;
    endfunction

    function bit has_written(int unsigned addr, int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            if (!written[(addr + i) % MEM_SIZE]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function logic [31:0] read_bytes(int unsigned addr, int unsigned count);
        logic [31:0] v;
        v = '0;
        for (int unsigned i = 0; i < count; i++) begin
            v = v | (32'(mem_img[(addr + i) % MEM_SIZE]) << (8 * i));
        end
        return v;
    endfunction

    function void write_bytes(int unsigned addr, int unsigned count, logic [31:0] v);
        int unsigned idx;
        for (int unsigned i = 0; i < count; i++) begin
            idx = (addr + i) % MEM_SIZE;
            mem_img[idx] = v[8*i +: 8];
            written[idx] = 1'b1;
        end
    endfunction

    // Predict the result of an accepted item and update the memory image.
    function void note_item(t_lsu_cmd c);
        int unsigned addr;
        t_lsu_result r;
        logic [31:0] v;
        addr = eff_addr(c.base, c.off);
        r = '0;
        n_items++;
        case (c.kind)
            rvlsu_pkg::KIND_LOAD: begin
                n_loads++;
                r.wb = 1'b1;
                case (c.wc)
                    rvlsu_pkg::F3_B: begin
                        v = read_bytes(addr, 1);
                        r.value = {{24{v[7]}}, v[7:0]};
                    end
                    rvlsu_pkg::F3_H: begin
                        v = read_bytes(addr, 2);
                        r.value = {{16{v[15]}}, v[15:0]};
                    end
                    rvlsu_pkg::F3_W:  r.value = read_bytes(addr, 4);
                    rvlsu_pkg::F3_BU: r.value = read_bytes(addr, 1);
                    rvlsu_pkg::F3_HU: r.value = read_bytes(addr, 2);
                    default: r.wb = 1'b0;
                endcase
            end
            rvlsu_pkg::KIND_STORE: begin
                n_stores++;
                case (c.wc)
                    rvlsu_pkg::F3_B: write_bytes(addr, 1, c.data);
                    rvlsu_pkg::F3_H: write_bytes(addr, 2, c.data);
                    rvlsu_pkg::F3_W: write_bytes(addr, 4, c.data);
                    default: ;
                endcase
            end
            default: n_other++;
        endcase
        if (r.wb) r.rd = c.rd;
        pending_q.push_back(r);
    endfunction

    function void flag(string msg);
        n_errors++;
        if (n_errors <= 10) $display("[%0t] MISMATCH: %s", $time, msg);
    endfunction

    function void check_result(logic [31:0] value, logic [4:0] rd, logic wb);
        t_lsu_result exp;
        n_checked++;
        if (pending_q.size() == 0) begin
            flag($sformatf("result with no item outstanding: value=%h rd=%0d wb=%b",
                           value, rd, wb));
            return;
        end
        exp = pending_q.pop_front();
        if (value !== exp.value || rd !== exp.rd || wb !== exp.wb) begin
            flag($sformatf("exp value=%h rd=%0d wb=%b, got value=%h rd=%0d wb=%b",
                           exp.value, exp.rd, exp.wb, value, rd, wb));
        end
    endfunction

    function int pending();
        return pending_q.size();
    endfunction
endclass

module tb_top;
    localparam int unsigned MEM_SIZE = rvlsu_pkg::MEM_BYTES_DEF;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_kind = '0;
    logic [2:0]         i_width_code = '0;
    logic [31:0]        i_base_value = '0;
    logic signed [11:0] i_offset = '0;
    logic [31:0]        i_store_data = '0;
    logic [4:0]         i_dest_reg = '0;
    logic [31:0]        o_load_value;
    logic [4:0]         o_dest_reg_out;
    logic               o_writes_back;
    logic               o_valid;

    lsu_scoreboard sb = new();

    riscv_load_store_unit_core #(.MEM_BYTES(MEM_SIZE)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_width_code   (i_width_code),
        .i_base_value   (i_base_value),
        .i_offset       (i_offset),
        .i_store_data   (i_store_data),
        .i_dest_reg     (i_dest_reg),
        .o_load_value   (o_load_value),
        .o_dest_reg_out (o_dest_reg_out),
        .o_writes_back  (o_writes_back),
        .o_valid        (o_valid)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_result(o_load_value, o_dest_reg_out, o_writes_back);
    end

    function automatic bit is_supported(logic [1:0] kind, logic [2:0] wc);
        if (kind == rvlsu_pkg::KIND_LOAD)
            return wc inside {rvlsu_pkg::F3_B, rvlsu_pkg::F3_H, rvlsu_pkg::F3_W,
                              rvlsu_pkg::F3_BU, rvlsu_pkg::F3_HU};
        return wc inside {rvlsu_pkg::F3_B, rvlsu_pkg::F3_H, rvlsu_pkg::F3_W};
    endfunction

    function automatic int unsigned width_bytes(logic [2:0] wc);
        case (wc)
            rvlsu_pkg::F3_B, rvlsu_pkg::F3_BU: return 1;
            rvlsu_pkg::F3_H, rvlsu_pkg::F3_HU: return 2;
            rvlsu_pkg::F3_W:                   return 4;
            default:                           return 0;
        endcase
    endfunction

    // Keep most traffic in a low window and at the top of memory so loads hit
    // stored data and accesses wrap across the memory end.
    function automatic int unsigned hot_addr();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(511);
        if (r < 90) return MEM_SIZE - 64 + $urandom_range(63);
        return $urandom_range(MEM_SIZE - 1);
    endfunction

    // Random base whose effective address lands on target.
    function automatic logic [31:0] base_for(int unsigned target, logic [11:0] off);
        logic [31:0] b;
        logic [31:0] a;
        b = $urandom;
        a = b + {{20{off[11]}}, off};
        return b + ((32'(target) - a) & 32'(MEM_SIZE - 1));
    endfunction

    function automatic logic [31:0] rand_data();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0) return 32'h0;
        if (r == 1) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    function automatic t_lsu_cmd random_cmd();
        t_lsu_cmd    c;
        int unsigned r;
        int unsigned tgt;
        bit          found;
        c.off  = 12'($urandom);
        c.data = rand_data();
        c.rd   = 5'($urandom);
        c.base = $urandom;
        r = $urandom_range(99);
        if (r >= 85) begin
            c.kind = ($urandom_range(1) != 0) ? KIND_RSVD : rvlsu_pkg::KIND_OTHER;
            c.wc   = 3'($urandom);
            return c;
        end
        c.kind = (r < 40) ? rvlsu_pkg::KIND_STORE : rvlsu_pkg::KIND_LOAD;
        if ($urandom_range(99) < 90) begin
            do c.wc = 3'($urandom); while (!is_supported(c.kind, c.wc));
        end else begin
            do c.wc = 3'($urandom); while (is_supported(c.kind, c.wc));
            return c;
        end
        if (c.kind == rvlsu_pkg::KIND_LOAD) begin
            found = 1'b0;
            for (int i = 0; i < 16 && !found; i++) begin
                tgt = hot_addr();
                found = sb.has_written(tgt, width_bytes(c.wc));
            end
            // fall back to a word store until enough memory has been written
            if (!found) begin
                c.kind = rvlsu_pkg::KIND_STORE;
                c.wc   = rvlsu_pkg::F3_W;
                tgt    = hot_addr();
            end
        end else begin
            tgt = hot_addr();
        end
        c.base = base_for(tgt, c.off);
        return c;
    endfunction

    // Present one item, optionally after an idle gap, and hold it until taken.
    task automatic drive_cmd(t_lsu_cmd c, int idle_pct);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_kind       <= c.kind;
        i_width_code <= c.wc;
        i_base_value <= c.base;
        i_offset     <= c.off;
        i_store_data <= c.data;
        i_dest_reg   <= c.rd;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_item(c);
    endtask

    task automatic directed(logic [1:0] kind, logic [2:0] wc, logic [31:0] base,
                            logic [11:0] off, logic [31:0] data, logic [4:0] rd);
        t_lsu_cmd c;
        c = '{kind: kind, wc: wc, base: base, off: off, data: data, rd: rd};
        drive_cmd(c, 0);
    endtask

    task automatic run_random(int n, int idle_pct);
        repeat (n) drive_cmd(random_cmd(), idle_pct);
    endtask

    initial begin
        int guard;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, every width, sign/zero extension, wrap across memory end
        directed(rvlsu_pkg::KIND_STORE, rvlsu_pkg::F3_W, 32'h0, 12'h000, 32'hFFFF_FFFF, 5'd0);
        directed(rvlsu_pkg::KIND_LOAD, rvlsu_pkg::F3_W, 32'h0, 12'h000, 32'h0, 5'd31);
        directed(rvlsu_pkg::KIND_LOAD, rvlsu_pkg::F3_B, 32'h0000_0800, 12'h800, 32'h0, 5'd1);
        directed(rvlsu_pkg::KIND_LOAD, rvlsu_pkg::F3_BU, 32'h0, 12'h001, 32'h0, 5'd2);
        directed(rvlsu_pkg::KIND_LOAD, rvlsu_pkg::F3_H, 32'h0, 12'h002, 32'h0, 5'd3);
        directed(rvlsu_pkg::KIND_LOAD, rvlsu_pkg::F3_HU, 32'h0, 12'h000, 32'h0, 5'd4);
        directed(rvlsu_pkg::KIND_STORE, rvlsu_pkg::F3_W, 32'hFFFF_FFFF, 12'hFFF,
                 32'h8001_8002, 5'd31);
        directed(rvlsu_pkg::KIND_LOAD, rvlsu_pkg::F3_W, 32'hFFFF_FFFF, 12'hFFF, 32'h0, 5'd5);
        directed(rvlsu_pkg::KIND_LOAD, rvlsu_pkg::F3_H, 32'h0000_F800, 12'h7FF, 32'h0, 5'd6);
        directed(rvlsu_pkg::KIND_LOAD, rvlsu_pkg::F3_B, 32'h0000_F800, 12'h7FF, 32'h0, 5'd7);
        directed(rvlsu_pkg::KIND_LOAD, rvlsu_pkg::F3_BU, 32'h0000_F800, 12'h7FF, 32'h0, 5'd8);
        directed(rvlsu_pkg::KIND_LOAD, rvlsu_pkg::F3_HU, 32'h7FFF_FFFE, 12'h000, 32'h0, 5'd9);
        directed(rvlsu_pkg::KIND_LOAD, rvlsu_pkg::F3_H, 32'h7FFF_FFFE, 12'h000, 32'h0, 5'd10);
        directed(rvlsu_pkg::KIND_STORE, rvlsu_pkg::F3_B, 32'h0, 12'h000, 32'h0, 5'd0);
        directed(rvlsu_pkg::KIND_STORE, rvlsu_pkg::F3_H, 32'h1234_0002, 12'h000,
                 32'h0000_007F, 5'd0);
        directed(rvlsu_pkg::KIND_LOAD, rvlsu_pkg::F3_W, 32'h0, 12'h000, 32'h0, 5'd11);
        // stores with unlisted widths and non-memory kinds must leave memory alone
        directed(rvlsu_pkg::KIND_STORE, rvlsu_pkg::F3_BU, 32'h0, 12'h000, 32'h1234_5678, 5'd31);
        directed(rvlsu_pkg::KIND_STORE, F3_RSVD_C, 32'h0, 12'h000, 32'hFFFF_FFFF, 5'd31);
        directed(rvlsu_pkg::KIND_LOAD, rvlsu_pkg::F3_W, 32'h0, 12'h000, 32'h0, 5'd12);
        directed(rvlsu_pkg::KIND_LOAD, F3_RSVD_A, 32'hFFFF_FFFF, 12'h7FF, 32'h0, 5'd31);
        directed(rvlsu_pkg::KIND_LOAD, F3_RSVD_B, 32'h0, 12'h800, 32'h0, 5'd31);
        directed(rvlsu_pkg::KIND_LOAD, F3_RSVD_C, 32'h0, 12'h000, 32'h0, 5'd31);
        directed(rvlsu_pkg::KIND_OTHER, rvlsu_pkg::F3_W, 32'h0, 12'h000, 32'hFFFF_FFFF, 5'd31);
        directed(KIND_RSVD, rvlsu_pkg::F3_W, 32'h0, 12'h000, 32'hFFFF_FFFF, 5'd31);
        directed(rvlsu_pkg::KIND_LOAD, rvlsu_pkg::F3_W, 32'h0, 12'h000, 32'h0, 5'd13);

        run_random(100, 0);
        run_random(100, 69);
        run_random(100, 22);
        run_random(100, 0);
        start <= 1'b0;

        guard = 0;
        while (sb.pending() != 0 && guard < 1000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
        if (sb.pending() != 0) sb.flag($sformatf("%0d results never arrived", sb.pending()));

        $display("Ran %0d items (%0d loads, %0d stores, %0d others) over four idle phases,",
                 sb.n_items, sb.n_loads, sb.n_stores, sb.n_other);
        $display("checked %0d results with %0d mismatches.", sb.n_checked, sb.n_errors);
        if (sb.n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout: run did not complete");
        $display("Verification failed");
        $finish;
    end
endmodule
